// ===== sv/vmab_pkg.sv =====
// Package for the VM ALU and branch unit: operation codes, widths and helpers.
// No dependencies.
`default_nettype none
package vmab_pkg;
	localparam int unsigned WordBits = 16;
	localparam int unsigned AddrBitsDefault = 17;
	localparam int unsigned PcBits = 17;
	localparam int unsigned DivStages = 16;

	typedef enum logic [3:0] {
		OP_JE = 4'd0, OP_JL = 4'd1, OP_JG = 4'd2, OP_DEC_CHK = 4'd3,
		OP_INC_CHK = 4'd4, OP_TEST = 4'd5, OP_AND = 4'd6, OP_ADD = 4'd7,
		OP_SUB = 4'd8, OP_MUL = 4'd9, OP_DIV = 4'd10, OP_JZ = 4'd11,
		OP_JUMP = 4'd12, OP_INC = 4'd13, OP_DEC = 4'd14, OP_NONE = 4'd15
	} op_t;

	typedef enum logic [1:0] {
		RC_NONE = 2'd0, RC_FALSE = 2'd1, RC_TRUE = 2'd2
	} ret_t;

	// Everything the stages carry besides the divider's running state.
	typedef struct packed {
		logic [WordBits-1:0] result;
		logic                wr_res;
		logic                wr_var;
		logic [PcBits-1:0]   npc;
		ret_t                rc;
		logic                fault;
		logic                is_div;
		logic                neg_q;
	} ctl_t;
endpackage : vmab_pkg
`default_nettype wire

// ===== sv/vm_alu_branch_unit.sv =====
// ALU and branch unit of the story virtual machine, top level.
// Depends on vmab_pkg.
//
// Usage: one instruction item enters on the input valid/ready channel and
// one result item leaves on the output valid/ready channel per instruction.
// Stage 1 decodes, evaluates compares, branch targets and the low half of the
// product, and starts the divide. Stages 2..17 each retire one quotient bit
// of the restoring divider. An accepted item is registered in stage 1 and
// then in each divide stage in order before it is offered on the output.
// Throughput is one item per cycle while the receiver does not stall; the
// pipeline length is set by the sixteen one-bit divide steps. Results leave
// in acceptance order. When the receiver stalls, every stage holds its item
// and in_ready falls only when every stage is full and the last one is not
// being drained; no item is lost or repeated. Reset clears all stage valid
// bits; payload registers are not reset. The block holds no architectural
// state.
`default_nettype none
module vm_alu_branch_unit
	import vmab_pkg::*;
#(
	parameter int unsigned ADDR_BITS = AddrBitsDefault
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [3:0]          kind,
	input  wire logic [15:0]         operand_a,
	input  wire logic [15:0]         operand_b,
	input  wire logic [15:0]         operand_c,
	input  wire logic [15:0]         operand_d,
	input  wire logic [2:0]          operand_count,
	input  wire logic [15:0]         variable_value,
	input  wire logic [7:0]          branch_first,
	input  wire logic [7:0]          branch_second,
	input  wire logic [PcBits-1:0]   pc_now,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [15:0]              result_value,
	output logic                     writes_result,
	output logic                     writes_variable,
	output logic [PcBits-1:0]        next_pc,
	output logic [1:0]               return_code,
	output logic                     divide_fault
);
	localparam int unsigned NS = DivStages + 1;
	localparam logic [PcBits-1:0] AddrMask = PcBits'((18'd1 << ADDR_BITS) - 18'd1);

	// Stage valid bits and payload; index 0 is stage 1.
	logic        vld_s [NS];
	ctl_t        ctl_s [NS];
	logic [15:0] rem_s [NS];
	logic [15:0] quo_s [NS];
	logic [15:0] dvs_s [NS];
	logic        adv [NS];

	// A stage advances when the stage after it can take it.
	always_comb begin
		adv[NS-1] = !vld_s[NS-1] || out_ready;
		for (int i = NS-2; i >= 0; i--) begin
			adv[i] = !vld_s[i] || adv[i+1];
		end
	end
	assign in_ready = adv[0];

	// Stage 1 decode.
	logic signed [15:0] sa, sb;
	logic [15:0] inc_v, dec_v;
	logic cond, is_br, sense, short_f;
	logic signed [13:0] off;
	logic [PcBits-1:0] pc_m, stepped, taken_pc;
	ctl_t c0;
	logic [15:0] abs_a, abs_b;
	op_t op;
	always_comb begin
		op = op_t'(kind);
		sa = signed'(operand_a);
		sb = signed'(operand_b);
		inc_v = variable_value + 16'd1;
		dec_v = variable_value - 16'd1;
		pc_m = pc_now & AddrMask;
		cond = 1'b0;
		is_br = 1'b0;
		c0 = '0;
		c0.npc = pc_m;
		c0.rc = RC_NONE;
		unique case (op)
			OP_JE: begin
				is_br = 1'b1;
				cond = (operand_count >= 3'd2 && operand_a == operand_b)
					|| (operand_count >= 3'd3 && operand_a == operand_c)
					|| (operand_count >= 3'd4 && operand_a == operand_d);
			end
			OP_JL: begin is_br = 1'b1; cond = sa < sb; end
			OP_JG: begin is_br = 1'b1; cond = sa > sb; end
			OP_DEC_CHK: begin
				is_br = 1'b1; cond = signed'(dec_v) < sb;
				c0.result = dec_v; c0.wr_var = 1'b1;
			end
			OP_INC_CHK: begin
				is_br = 1'b1; cond = signed'(inc_v) > sb;
				c0.result = inc_v; c0.wr_var = 1'b1;
			end
			OP_TEST: begin is_br = 1'b1; cond = (operand_a & operand_b) == operand_b; end
			OP_AND: begin c0.result = operand_a & operand_b; c0.wr_res = 1'b1; end
			OP_ADD: begin c0.result = operand_a + operand_b; c0.wr_res = 1'b1; end
			OP_SUB: begin c0.result = operand_a - operand_b; c0.wr_res = 1'b1; end
			// The low half of the product is the same for signed and unsigned words.
			OP_MUL: begin c0.result = operand_a * operand_b; c0.wr_res = 1'b1; end
			OP_DIV: begin
				c0.wr_res = 1'b1; c0.is_div = 1'b1;
				c0.fault = operand_b == 16'd0;
				c0.neg_q = operand_a[15] ^ operand_b[15];
			end
			OP_JZ: begin is_br = 1'b1; cond = operand_a == 16'd0; end
			OP_JUMP: c0.npc = (pc_m + PcBits'({{(PcBits-16){sa[15]}}, operand_a})
				- PcBits'(2)) & AddrMask;
			OP_INC: begin c0.result = inc_v; c0.wr_var = 1'b1; end
			OP_DEC: begin c0.result = dec_v; c0.wr_var = 1'b1; end
			default: ;
		endcase
		sense = branch_first[7];
		short_f = branch_first[6];
		off = short_f ? {8'd0, branch_first[5:0]} : {branch_first[5:0], branch_second};
		stepped = (pc_m + (short_f ? PcBits'(1) : PcBits'(2))) & AddrMask;
		taken_pc = (stepped + PcBits'({{(PcBits-14){off[13]}}, off}) - PcBits'(2))
			& AddrMask;
		if (is_br) begin
			c0.npc = stepped;
			if (sense == cond) begin
				if (off == 14'sd0) c0.rc = RC_FALSE;
				else if (off == 14'sd1) c0.rc = RC_TRUE;
				else c0.npc = taken_pc;
			end
		end
		abs_a = operand_a[15] ? 16'd0 - operand_a : operand_a;
		abs_b = operand_b[15] ? 16'd0 - operand_b : operand_b;
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NS; i++) vld_s[i] <= 1'b0;
		end else begin
			if (adv[0]) vld_s[0] <= in_valid;
			for (int i = 1; i < NS; i++) begin
				if (adv[i]) vld_s[i] <= vld_s[i-1];
			end
		end
	end

	// Stage payloads: stage 1 loads, stages 2..17 each do one divide step.
	logic [16:0] trial [NS];
	always_comb begin
		for (int i = 0; i < NS; i++) begin
			trial[i] = {rem_s[i], quo_s[i][15]} - {1'b0, dvs_s[i]};
		end
	end
	always_ff @(posedge clk) begin
		if (adv[0] && in_valid) begin
			ctl_s[0] <= c0;
			rem_s[0] <= '0;
			quo_s[0] <= abs_a;
			dvs_s[0] <= abs_b;
		end
		for (int i = 1; i < NS; i++) begin
			if (adv[i] && vld_s[i-1]) begin
				ctl_s[i] <= ctl_s[i-1];
				dvs_s[i] <= dvs_s[i-1];
				if (!trial[i-1][16]) begin
					rem_s[i] <= trial[i-1][15:0];
					quo_s[i] <= {quo_s[i-1][14:0], 1'b1};
				end else begin
					rem_s[i] <= {rem_s[i-1][14:0], quo_s[i-1][15]};
					quo_s[i] <= {quo_s[i-1][14:0], 1'b0};
				end
			end
		end
	end

	// Output formatting.
	ctl_t co;
	always_comb begin
		co = ctl_s[NS-1];
		out_valid = vld_s[NS-1];
		result_value = co.result;
		if (co.is_div) begin
			if (co.fault) result_value = 16'd0;
			else result_value = co.neg_q ? 16'd0 - quo_s[NS-1] : quo_s[NS-1];
		end
		writes_result = co.wr_res;
		writes_variable = co.wr_var;
		next_pc = co.npc;
		return_code = co.rc;
		divide_fault = co.fault;
	end

	// Assertions.
	a_fault_div: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_fault |-> writes_result && result_value == 16'd0)
		else $error("fault without div result");
	a_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(writes_result && writes_variable))
		else $error("both write flags set");
	a_ret_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && return_code != RC_NONE |-> !writes_result)
		else $error("return with store");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(next_pc))
		else $error("stalled item changed");
endmodule : vm_alu_branch_unit
`default_nettype wire

// ===== sim/vm_alu_branch_unit_checker.sv =====
// Checker for the VM ALU and branch unit: watches both channels, predicts each
// result from the accepted instruction and compares all fields at once. Depends on vmab_pkg.
module vm_alu_branch_unit_checker
	import vmab_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [3:0]  kind,
	input  logic [15:0] operand_a,
	input  logic [15:0] operand_b,
	input  logic [15:0] operand_c,
	input  logic [15:0] operand_d,
	input  logic [2:0]  operand_count,
	input  logic [15:0] variable_value,
	input  logic [7:0]  branch_first,
	input  logic [7:0]  branch_second,
	input  logic [16:0] pc_now,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [15:0] result_value,
	input  logic        writes_result,
	input  logic        writes_variable,
	input  logic [16:0] next_pc,
	input  logic [1:0]  return_code,
	input  logic        divide_fault,
	output int          fail_count,
	output int          pending_results,
	output int          results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [15:0] value;
		logic        wr_res;
		logic        wr_var;
		logic [16:0] npc;
		logic [1:0]  rc;
		logic        fault;
	} exec_result_t;

	exec_result_t expected_results[$];

	// Execute one instruction the way the machine defines it.
	function automatic exec_result_t execute_instr(
		logic [3:0] op, logic [15:0] a, logic [15:0] b, logic [15:0] c,
		logic [15:0] d, logic [2:0] cnt, logic [15:0] var_val,
		logic [7:0] b1, logic [7:0] b2, logic [16:0] pc);
		exec_result_t r;
		logic is_branch;
		logic cond;
		logic [15:0] t;
		logic signed [31:0] prod;
		logic [13:0] raw_off;
		logic signed [17:0] off;
		logic [16:0] stepped;
		r = '0;
		r.npc = pc;
		is_branch = 1'b0;
		cond = 1'b0;
		case (op)
			OP_JE: begin
				is_branch = 1'b1;
				cond = (cnt >= 2 && a == b) || (cnt >= 3 && a == c) || (cnt >= 4 && a == d);
			end
			OP_JL: begin
				is_branch = 1'b1;
				cond = $signed(a) < $signed(b);
			end
			OP_JG: begin
				is_branch = 1'b1;
				cond = $signed(a) > $signed(b);
			end
			OP_DEC_CHK: begin
				t = var_val - 16'd1;
				r.value = t;
				r.wr_var = 1'b1;
				is_branch = 1'b1;
				cond = $signed(t) < $signed(b);
			end
			OP_INC_CHK: begin
				t = var_val + 16'd1;
				r.value = t;
				r.wr_var = 1'b1;
				is_branch = 1'b1;
				cond = $signed(t) > $signed(b);
			end
			OP_TEST: begin
				is_branch = 1'b1;
				cond = (a & b) == b;
			end
			OP_AND: begin
				r.value = a & b;
				r.wr_res = 1'b1;
			end
			OP_ADD: begin
				r.value = a + b;
				r.wr_res = 1'b1;
			end
			OP_SUB: begin
				r.value = a - b;
				r.wr_res = 1'b1;
			end
			OP_MUL: begin
				prod = $signed(a) * $signed(b);
				r.value = prod[15:0];
				r.wr_res = 1'b1;
			end
			OP_DIV: begin
				r.wr_res = 1'b1;
				if (b == 16'd0) begin
					r.fault = 1'b1;
				end else begin
					// Truncating divide; the one overflow case wraps by taking the low bits.
					prod = 32'(signed'(a)) / 32'(signed'(b));
					r.value = prod[15:0];
				end
			end
			OP_JZ: begin
				is_branch = 1'b1;
				cond = a == 16'd0;
			end
			OP_JUMP: begin
				r.npc = pc + 17'(signed'(a)) - 17'd2;
			end
			OP_INC: begin
				r.value = var_val + 16'd1;
				r.wr_var = 1'b1;
			end
			OP_DEC: begin
				r.value = var_val - 16'd1;
				r.wr_var = 1'b1;
			end
			default: begin
			end
		endcase
		if (is_branch) begin
			if (b1[6]) begin
				off = 18'(b1[5:0]);
				stepped = pc + 17'd1;
			end else begin
				raw_off = {b1[5:0], b2};
				off = 18'(signed'(raw_off));
				stepped = pc + 17'd2;
			end
			r.npc = stepped;
			if (b1[7] == cond) begin
				if (off == 0)
					r.rc = RC_FALSE;
				else if (off == 1)
					r.rc = RC_TRUE;
				else
					r.npc = stepped + off[16:0] - 17'd2;
			end
		end
		return r;
	endfunction

	assign pending_results = expected_results.size();

	// Predict on input acceptance, compare on output acceptance.
	always @(posedge clk or negedge arst_n) begin
		exec_result_t seen;
		exec_result_t want;
		if (!arst_n) begin
			fail_count <= 0;
			results_seen <= 0;
		end else begin
			if (in_valid && in_ready)
				expected_results.push_back(execute_instr(kind, operand_a, operand_b,
					operand_c, operand_d, operand_count, variable_value,
					branch_first, branch_second, pc_now));
			if (out_valid && out_ready) begin
				results_seen <= results_seen + 1;
				seen = {result_value, writes_result, writes_variable, next_pc,
					return_code, divide_fault};
				if (expected_results.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result item %p", seen);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_results.pop_front();
					if (seen !== want) begin
						if (fail_count < 10)
							$display("mismatch: expected %p actual %p", want, seen);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

// ===== sim/tb.sv =====
// Testbench top for the VM ALU and branch unit: drives instruction items with
// random gaps and stalls. Uses vmab_pkg, vm_alu_branch_unit and its checker.
module tb;
	import vmab_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WatchdogLimit = 5000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [3:0]  kind = '0;
	logic [15:0] operand_a = '0, operand_b = '0, operand_c = '0, operand_d = '0;
	logic [2:0]  operand_count = '0;
	logic [15:0] variable_value = '0;
	logic [7:0]  branch_first = '0, branch_second = '0;
	logic [16:0] pc_now = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] result_value;
	logic        writes_result, writes_variable, divide_fault;
	logic [16:0] next_pc;
	logic [1:0]  return_code;
	int          fail_count, pending_results, results_seen;
	int          idle_cycles = 0;
	int          items_sent = 0;
	logic        stim_done = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	vm_alu_branch_unit u_top (.*);

	vm_alu_branch_unit_checker u_checker (.*);

	// Short gaps mostly, an occasional long one.
	function automatic int gap_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		else if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [15:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			3: return 16'h7FFF;
			4: return 16'($urandom_range(0, 4));
			default: return 16'($urandom);
		endcase
	endfunction

	// Present one item at the falling edge and hold it until accepted.
	// Valid drops only for a gap; with no gap the next item follows directly.
	task automatic send_instr(logic [3:0] op, logic [15:0] a, logic [15:0] b,
		logic [15:0] c, logic [15:0] d, logic [2:0] cnt, logic [15:0] var_val,
		logic [7:0] b1, logic [7:0] b2, logic [16:0] pc);
		int gap;
		gap = gap_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= op;
		operand_a <= a;
		operand_b <= b;
		operand_c <= c;
		operand_d <= d;
		operand_count <= cnt;
		variable_value <= var_val;
		branch_first <= b1;
		branch_second <= b2;
		pc_now <= pc;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_random();
		logic [15:0] a;
		a = rand_word();
		// Bias operands to equal values so compares take both outcomes.
		send_instr(4'($urandom_range(0, 15)), a,
			($urandom_range(0, 3) == 0) ? a : rand_word(),
			($urandom_range(0, 3) == 0) ? a : rand_word(),
			($urandom_range(0, 3) == 0) ? a : rand_word(),
			3'($urandom), rand_word(),
			($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 1) | ($urandom & 8'hC0))
				: 8'($urandom),
			8'($urandom), 17'($urandom));
	endtask

	// Receiver stalls at random, with stall-free stretches.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 3) == 0) begin
				stall = gap_len();
				if (stall != 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(negedge clk);
				end
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(negedge clk);
		end
	end

	// Watchdog on cycles where nothing is accepted.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || stim_done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit) begin
			$display("tb: errors");
			$finish;
		end
	end

	initial begin
		int wait_cycles;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		// Directed: every operation plus the named corner cases.
		send_instr(OP_JE, 16'd5, 16'd6, 16'd7, 16'd5, 3'd4, 16'd0, 8'hC5, 8'h00, 17'h100);
		send_instr(OP_JE, 16'd5, 16'd5, 16'd5, 16'd5, 3'd1, 16'd0, 8'hC5, 8'h00, 17'h100);
		send_instr(OP_JE, 16'd5, 16'd0, 16'd0, 16'd5, 3'd7, 16'd0, 8'h80, 8'h00, 17'h100);
		send_instr(OP_JL, 16'h8000, 16'h7FFF, 0, 0, 3'd2, 0, 8'h80, 8'h01, 17'h1FFFF);
		send_instr(OP_JG, 16'h7FFF, 16'h8000, 0, 0, 3'd2, 0, 8'hBF, 8'hFF, 17'h0);
		send_instr(OP_JG, 16'h7FFF, 16'h8000, 0, 0, 3'd2, 0, 8'hA0, 8'h00, 17'h10);
		send_instr(OP_DEC_CHK, 16'd1, 16'h0000, 0, 0, 3'd2, 16'h8000, 8'hC2, 0, 17'h55);
		send_instr(OP_INC_CHK, 16'd1, 16'h0000, 0, 0, 3'd2, 16'h7FFF, 8'h7F, 0, 17'h55);
		send_instr(OP_TEST, 16'hF0F0, 16'hF000, 0, 0, 3'd2, 0, 8'h40, 8'h00, 17'h1FFFF);
		send_instr(OP_AND, 16'hFFFF, 16'h1234, 0, 0, 3'd2, 0, 0, 0, 17'h22);
		send_instr(OP_ADD, 16'hFFFF, 16'h0001, 0, 0, 3'd2, 0, 0, 0, 17'h22);
		send_instr(OP_SUB, 16'h0000, 16'h0001, 0, 0, 3'd2, 0, 0, 0, 17'h22);
		send_instr(OP_MUL, 16'h8000, 16'hFFFF, 0, 0, 3'd2, 0, 0, 0, 17'h22);
		send_instr(OP_DIV, 16'hFFF9, 16'h0002, 0, 0, 3'd2, 0, 0, 0, 17'h22);
		send_instr(OP_DIV, 16'h1234, 16'h0000, 0, 0, 3'd2, 0, 0, 0, 17'h22);
		send_instr(OP_DIV, 16'h8000, 16'hFFFF, 0, 0, 3'd2, 0, 0, 0, 17'h22);
		send_instr(OP_JZ, 16'h0000, 0, 0, 0, 3'd2, 0, 8'hFF, 8'hFF, 17'h1FFFF);
		send_instr(OP_JUMP, 16'h8000, 0, 0, 0, 3'd2, 0, 0, 0, 17'h00001);
		send_instr(OP_JUMP, 16'h7FFF, 0, 0, 0, 3'd2, 0, 0, 0, 17'h1FFFF);
		send_instr(OP_INC, 16'd3, 0, 0, 0, 3'd2, 16'hFFFF, 0, 0, 17'h9);
		send_instr(OP_DEC, 16'd3, 0, 0, 0, 3'd2, 16'h0000, 0, 0, 17'h9);
		send_instr(OP_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7, 16'hFFFF,
			8'hFF, 8'hFF, 17'h1FFFF);
		repeat (1100) send_random();
		in_valid <= 1'b0;
		stim_done <= 1'b1;
		wait_cycles = 0;
		while (pending_results != 0 && wait_cycles < WatchdogLimit) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (40) @(posedge clk);
		$display("Sent %0d instruction items over all fifteen operations and unused codes;",
			items_sent);
		$display("%0d results compared, %0d mismatches.", results_seen, fail_count);
		if (fail_count == 0 && pending_results == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end
endmodule

// ===== sim.f =====
sv/vmab_pkg.sv
sv/vm_alu_branch_unit.sv
sim/vm_alu_branch_unit_checker.sv
sim/tb.sv
